// ----- rtl/hibm_pkg.sv -----
// Shared constants, types and codes of the hybrid image blur and merge block.
package hibm_pkg;

  // Frame geometry
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int MIN_DIM      = 3;
  localparam int RESET_WIDTH  = 512;
  localparam int RESET_HEIGHT = 512;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WDIM_W       = COL_W + 1;
  localparam int HDIM_W       = ROW_W + 1;

  // Row buffers: one bank per row slot, rows rotate through the slots
  localparam int NUM_SLOTS = 3;
  localparam int SLOT_W    = 2;

  // Data widths
  localparam int PIX_W = 8;
  localparam int CSUM_W = PIX_W + 2;
  localparam int SUM_W  = PIX_W + 4;
  localparam int OUT_W  = 10;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Input commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One line buffer word: the pixel of each image at the same place
  typedef struct packed {
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
  } pair_t;

  // One window column, top to bottom
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } pix_col_t;

  // Control carried alongside the lane results into the merge stage
  typedef struct packed {
    logic valid;
    logic frame_end;
  } lane_ctl_t;

  // One queued result
  typedef struct packed {
    logic signed [OUT_W-1:0] merged;
    logic                    frame_end;
  } res_t;

endpackage

// ----- rtl/hybrid_image_blur_merge.sv -----
// Top level: raster counters, line buffers, two blur lanes and the merge stage.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------------
//  in       | sink      | in_valid_i/in_ready_o  | cmd_i, pixel_a_i, pixel_b_i
//  out      | source    | out_valid_o/out_ready_i| merged_twice_o (signed), frame_end_o
//  cfg      | sink      | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One input transfer per clock while in_ready_o is high. The transfer that causes a result
// passes registered stages: accept and line buffer read, blur lanes, merge into the queue.
// The four-entry result queue and a credit count set in_ready_o; with out_ready_i held
// high the block never stalls. The line buffers are not cleared at reset: every window
// read touches only pixels already written in the current frame.
// cfg_ready_o is always high; a write to a known index restarts the frame.
module hybrid_image_blur_merge (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // pixel / flush channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  cmd_i,
  input  logic [hibm_pkg::PIX_W-1:0]            pixel_a_i,
  input  logic [hibm_pkg::PIX_W-1:0]            pixel_b_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [hibm_pkg::OUT_W-1:0]     merged_twice_o,
  output logic                                  frame_end_o,
  // configuration channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [hibm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [hibm_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int CMPW_W = (hibm_pkg::WDIM_W > hibm_pkg::CFG_DATA_W) ?
                          hibm_pkg::WDIM_W : hibm_pkg::CFG_DATA_W;
  localparam int CMPH_W = (hibm_pkg::HDIM_W > hibm_pkg::CFG_DATA_W) ?
                          hibm_pkg::HDIM_W : hibm_pkg::CFG_DATA_W;

  // Control of the item in the read stage
  typedef struct packed {
    logic [hibm_pkg::SLOT_W-1:0] top_sel;
    logic [hibm_pkg::SLOT_W-1:0] mid_sel;
    logic [hibm_pkg::SLOT_W-1:0] bot_sel;
    logic                        first_col;
    logic                        last;
  } rd_ctl_t;

  // Clamp a written size into its legal range
  function automatic logic [hibm_pkg::WDIM_W-1:0] clamp_w(
    logic [hibm_pkg::CFG_DATA_W-1:0] value
  );
    logic [CMPW_W-1:0] v;
    v = CMPW_W'(value);
    if (v < CMPW_W'(hibm_pkg::MIN_DIM)) begin
      v = CMPW_W'(hibm_pkg::MIN_DIM);
    end else if (v > CMPW_W'(hibm_pkg::MAX_WIDTH)) begin
      v = CMPW_W'(hibm_pkg::MAX_WIDTH);
    end
    clamp_w = hibm_pkg::WDIM_W'(v);
  endfunction

  function automatic logic [hibm_pkg::HDIM_W-1:0] clamp_h(
    logic [hibm_pkg::CFG_DATA_W-1:0] value
  );
    logic [CMPH_W-1:0] v;
    v = CMPH_W'(value);
    if (v < CMPH_W'(hibm_pkg::MIN_DIM)) begin
      v = CMPH_W'(hibm_pkg::MIN_DIM);
    end else if (v > CMPH_W'(hibm_pkg::MAX_HEIGHT)) begin
      v = CMPH_W'(hibm_pkg::MAX_HEIGHT);
    end
    clamp_h = hibm_pkg::HDIM_W'(v);
  endfunction

  // Row slots rotate 0, 1, 2, 0, ...
  function automatic logic [hibm_pkg::SLOT_W-1:0] slot_next(logic [hibm_pkg::SLOT_W-1:0] s);
    slot_next = (s == hibm_pkg::SLOT_W'(hibm_pkg::NUM_SLOTS - 1)) ? '0 :
                s + hibm_pkg::SLOT_W'(1);
  endfunction

  function automatic logic [hibm_pkg::SLOT_W-1:0] slot_prev(logic [hibm_pkg::SLOT_W-1:0] s);
    slot_prev = (s == '0) ? hibm_pkg::SLOT_W'(hibm_pkg::NUM_SLOTS - 1) :
                s - hibm_pkg::SLOT_W'(1);
  endfunction

  // ---------------------------------------------------------------------------------
  // Size registers and raster counters
  // ---------------------------------------------------------------------------------
  logic [hibm_pkg::WDIM_W-1:0] eff_w_q, eff_w_d;
  logic [hibm_pkg::HDIM_W-1:0] eff_h_q, eff_h_d;
  logic [hibm_pkg::ROW_W-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [hibm_pkg::COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [hibm_pkg::SLOT_W-1:0] in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic                        in_done_q, in_done_d;

  logic                        accept, cfg_we, is_pixel, wr_en, emit, last;
  logic                        col_wrap, row_wrap, done_now, need_ok;
  logic [hibm_pkg::WDIM_W-1:0] in_col_inc, out_col_inc;
  logic [hibm_pkg::HDIM_W-1:0] in_row_inc, out_row_inc;
  logic [hibm_pkg::ROW_W-1:0]  need_row;
  logic [hibm_pkg::COL_W-1:0]  need_col, rd_col_right;
  logic [hibm_pkg::FIFO_CNT_W-1:0] fill;
  logic [hibm_pkg::FIFO_CNT_W:0]   credits_used;
  rd_ctl_t                     rd_ctl;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    in_col_inc  = hibm_pkg::WDIM_W'(in_col_q) + hibm_pkg::WDIM_W'(1);
    in_row_inc  = hibm_pkg::HDIM_W'(in_row_q) + hibm_pkg::HDIM_W'(1);
    out_col_inc = hibm_pkg::WDIM_W'(out_col_q) + hibm_pkg::WDIM_W'(1);
    out_row_inc = hibm_pkg::HDIM_W'(out_row_q) + hibm_pkg::HDIM_W'(1);
    col_wrap    = (in_col_inc >= eff_w_q);
    row_wrap    = (in_row_inc >= eff_h_q);

    // A pixel after the frame is complete acts as a flush step
    is_pixel = (cmd_i == hibm_pkg::CMD_PIXEL) && !in_done_q;
    wr_en    = accept && is_pixel;
    done_now = is_pixel && col_wrap && row_wrap;

    // Bottom-right neighbour of the next result, clamped to the frame
    need_row = (out_row_inc < eff_h_q) ? hibm_pkg::ROW_W'(out_row_inc) : out_row_q;
    need_col = (out_col_inc < eff_w_q) ? hibm_pkg::COL_W'(out_col_inc) : out_col_q;
    // Raster compare against the pixel written in this transfer
    need_ok  = (need_row < in_row_q) || ((need_row == in_row_q) && (need_col <= in_col_q));

    emit = accept && (in_done_q || (is_pixel && (done_now || need_ok)));
    last = (out_row_inc == eff_h_q) && (out_col_inc == eff_w_q);

    rd_col_right      = need_col;
    rd_ctl.top_sel    = (out_row_q == '0) ? out_slot_q : slot_prev(out_slot_q);
    rd_ctl.mid_sel    = out_slot_q;
    rd_ctl.bot_sel    = (out_row_inc < eff_h_q) ? slot_next(out_slot_q) : out_slot_q;
    rd_ctl.first_col  = (out_col_q == '0);
    rd_ctl.last       = last;
  end

  always_comb begin
    eff_w_d    = eff_w_q;
    eff_h_d    = eff_h_q;
    in_row_d   = in_row_q;
    in_col_d   = in_col_q;
    in_slot_d  = in_slot_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_slot_d = out_slot_q;
    in_done_d  = in_done_q;

    priority if (cfg_we) begin
      // Restart the frame on a write to a known register; line contents stay
      if (cfg_index_i == hibm_pkg::CFG_IMAGE_WIDTH || cfg_index_i == hibm_pkg::CFG_IMAGE_HEIGHT)
      begin
        if (cfg_index_i == hibm_pkg::CFG_IMAGE_WIDTH) begin
          eff_w_d = clamp_w(cfg_data_i);
        end else begin
          eff_h_d = clamp_h(cfg_data_i);
        end
        in_row_d   = '0;
        in_col_d   = '0;
        in_slot_d  = '0;
        out_row_d  = '0;
        out_col_d  = '0;
        out_slot_d = '0;
        in_done_d  = 1'b0;
      end
    end else if (accept) begin
      if (wr_en) begin
        if (col_wrap) begin
          in_col_d = '0;
          if (row_wrap) begin
            in_row_d  = '0;
            in_slot_d = '0;
            in_done_d = 1'b1;
          end else begin
            in_row_d  = hibm_pkg::ROW_W'(in_row_inc);
            in_slot_d = slot_next(in_slot_q);
          end
        end else begin
          in_col_d = hibm_pkg::COL_W'(in_col_inc);
        end
      end
      if (emit) begin
        if (last) begin
          // Frame drained: start over
          in_row_d   = '0;
          in_col_d   = '0;
          in_slot_d  = '0;
          out_row_d  = '0;
          out_col_d  = '0;
          out_slot_d = '0;
          in_done_d  = 1'b0;
        end else if (out_col_inc >= eff_w_q) begin
          out_col_d  = '0;
          out_row_d  = hibm_pkg::ROW_W'(out_row_inc);
          out_slot_d = slot_next(out_slot_q);
        end else begin
          out_col_d = hibm_pkg::COL_W'(out_col_inc);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q    <= hibm_pkg::WDIM_W'(hibm_pkg::RESET_WIDTH);
      eff_h_q    <= hibm_pkg::HDIM_W'(hibm_pkg::RESET_HEIGHT);
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_slot_q  <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_slot_q <= '0;
      in_done_q  <= 1'b0;
    end else begin
      eff_w_q    <= eff_w_d;
      eff_h_q    <= eff_h_d;
      in_row_q   <= in_row_d;
      in_col_q   <= in_col_d;
      in_slot_q  <= in_slot_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_slot_q <= out_slot_d;
      in_done_q  <= in_done_d;
    end
  end

  // ---------------------------------------------------------------------------------
  // Line buffers: one bank per row slot; both read ports take the same two columns
  // ---------------------------------------------------------------------------------
  hibm_pkg::pair_t wr_pair;
  hibm_pkg::pair_t bank_rd0 [hibm_pkg::NUM_SLOTS];
  hibm_pkg::pair_t bank_rd1 [hibm_pkg::NUM_SLOTS];

  assign wr_pair.a = pixel_a_i;
  assign wr_pair.b = pixel_b_i;

  for (genvar k = 0; k < hibm_pkg::NUM_SLOTS; k++) begin : g_bank
    hibm_line_bank u_bank (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .we_i     (wr_en && (in_slot_q == hibm_pkg::SLOT_W'(k))),
      .waddr_i  (in_col_q),
      .wdata_i  (wr_pair),
      .raddr0_i (out_col_q),
      .raddr1_i (rd_col_right),
      .rdata0_o (bank_rd0[k]),
      .rdata1_o (bank_rd1[k])
    );
  end

  // ---------------------------------------------------------------------------------
  // Read stage: build the two 3x3 windows
  // ---------------------------------------------------------------------------------
  logic               p1_valid_q, p2_valid_q, p2_last_q;
  rd_ctl_t            p1_ctl_q;
  hibm_pkg::pix_col_t mid_a, mid_b, right_a, right_b, left_a, left_b;
  hibm_pkg::pix_col_t prev_a_q, prev_b_q;

  always_comb begin
    mid_a.top   = bank_rd0[p1_ctl_q.top_sel].a;
    mid_a.mid   = bank_rd0[p1_ctl_q.mid_sel].a;
    mid_a.bot   = bank_rd0[p1_ctl_q.bot_sel].a;
    mid_b.top   = bank_rd0[p1_ctl_q.top_sel].b;
    mid_b.mid   = bank_rd0[p1_ctl_q.mid_sel].b;
    mid_b.bot   = bank_rd0[p1_ctl_q.bot_sel].b;
    right_a.top = bank_rd1[p1_ctl_q.top_sel].a;
    right_a.mid = bank_rd1[p1_ctl_q.mid_sel].a;
    right_a.bot = bank_rd1[p1_ctl_q.bot_sel].a;
    right_b.top = bank_rd1[p1_ctl_q.top_sel].b;
    right_b.mid = bank_rd1[p1_ctl_q.mid_sel].b;
    right_b.bot = bank_rd1[p1_ctl_q.bot_sel].b;
    // Left edge clamps onto the centre column; otherwise reuse the last centre column
    left_a      = p1_ctl_q.first_col ? mid_a : prev_a_q;
    left_b      = p1_ctl_q.first_col ? mid_b : prev_b_q;
  end

  always_ff @(posedge clk_i) begin
    p1_ctl_q <= rd_ctl;
    if (p1_valid_q) begin
      prev_a_q <= mid_a;
      prev_b_q <= mid_b;
    end
    p2_last_q <= p1_ctl_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= emit;
      p2_valid_q <= p1_valid_q;
    end
  end

  // ---------------------------------------------------------------------------------
  // Blur lanes, one per image
  // ---------------------------------------------------------------------------------
  logic [hibm_pkg::PIX_W-1:0] blur_a, blur_b, centre_b;

  hibm_blur_lane u_lane_a (
    .clk_i    (clk_i),
    .left_i   (left_a),
    .mid_i    (mid_a),
    .right_i  (right_a),
    .blur_o   (blur_a),
    .centre_o ()
  );

  hibm_blur_lane u_lane_b (
    .clk_i    (clk_i),
    .left_i   (left_b),
    .mid_i    (mid_b),
    .right_i  (right_b),
    .blur_o   (blur_b),
    .centre_o (centre_b)
  );

  // ---------------------------------------------------------------------------------
  // Merge and result queue
  // ---------------------------------------------------------------------------------
  hibm_pkg::lane_ctl_t merge_ctl;

  assign merge_ctl.valid     = p2_valid_q;
  assign merge_ctl.frame_end = p2_last_q;

  hibm_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (merge_ctl),
    .blur_a_i       (blur_a),
    .blur_b_i       (blur_b),
    .centre_b_i     (centre_b),
    .fill_o         (fill),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .merged_twice_o (merged_twice_o),
    .frame_end_o    (frame_end_o)
  );

  // Hold off input while the queue could not take every result still in flight
  assign credits_used = (hibm_pkg::FIFO_CNT_W + 1)'(fill)
                      + (hibm_pkg::FIFO_CNT_W + 1)'(p1_valid_q)
                      + (hibm_pkg::FIFO_CNT_W + 1)'(p2_valid_q);
  assign in_ready_o   = (credits_used < (hibm_pkg::FIFO_CNT_W + 1)'(hibm_pkg::FIFO_DEPTH));

endmodule

// ----- rtl/hibm_line_bank.sv -----
// One row slot of the line buffers: both images, one write and two read ports.
module hibm_line_bank (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [hibm_pkg::COL_W-1:0] waddr_i,
  input  hibm_pkg::pair_t           wdata_i,
  input  logic [hibm_pkg::COL_W-1:0] raddr0_i,
  input  logic [hibm_pkg::COL_W-1:0] raddr1_i,
  output hibm_pkg::pair_t           rdata0_o,
  output hibm_pkg::pair_t           rdata1_o
);

  hibm_pkg::pair_t mem_q [hibm_pkg::MAX_WIDTH];
  hibm_pkg::pair_t rd0_q, rd1_q, wdata_q;
  logic            hit0_q, hit1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd0_q   <= mem_q[raddr0_i];
    rd1_q   <= mem_q[raddr1_i];
    wdata_q <= wdata_i;
  end

  // A read of the word written in the same cycle must see the new pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit0_q <= 1'b0;
      hit1_q <= 1'b0;
    end else begin
      hit0_q <= we_i && (waddr_i == raddr0_i);
      hit1_q <= we_i && (waddr_i == raddr1_i);
    end
  end

  assign rdata0_o = hit0_q ? wdata_q : rd0_q;
  assign rdata1_o = hit1_q ? wdata_q : rd1_q;

endmodule

// ----- rtl/hibm_blur_lane.sv -----
// One blur lane: 1-2-1 by 1-2-1 weighted sum of a 3x3 window, divided by 16.
module hibm_blur_lane (
  input  logic                       clk_i,
  input  hibm_pkg::pix_col_t         left_i,
  input  hibm_pkg::pix_col_t         mid_i,
  input  hibm_pkg::pix_col_t         right_i,
  output logic [hibm_pkg::PIX_W-1:0] blur_o,
  output logic [hibm_pkg::PIX_W-1:0] centre_o
);

  logic [hibm_pkg::CSUM_W-1:0] sum_l, sum_m, sum_r;
  logic [hibm_pkg::SUM_W-1:0]  total;
  logic [hibm_pkg::PIX_W-1:0]  blur_d, blur_q, centre_q;

  function automatic logic [hibm_pkg::CSUM_W-1:0] col_sum(hibm_pkg::pix_col_t c);
    col_sum = hibm_pkg::CSUM_W'(c.top) + {1'b0, c.mid, 1'b0} + hibm_pkg::CSUM_W'(c.bot);
  endfunction

  always_comb begin
    sum_l  = col_sum(left_i);
    sum_m  = col_sum(mid_i);
    sum_r  = col_sum(right_i);
    total  = hibm_pkg::SUM_W'(sum_l) + {1'b0, sum_m, 1'b0} + hibm_pkg::SUM_W'(sum_r);
    blur_d = total[hibm_pkg::SUM_W-1:4];
  end

  always_ff @(posedge clk_i) begin
    blur_q   <= blur_d;
    centre_q <= mid_i.mid;
  end

  assign blur_o   = blur_q;
  assign centre_o = centre_q;

endmodule

// ----- rtl/hibm_merge.sv -----
// Merge stage: low-pass A plus high-pass B, then a small result queue.
module hibm_merge (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  hibm_pkg::lane_ctl_t                  ctl_i,
  input  logic [hibm_pkg::PIX_W-1:0]           blur_a_i,
  input  logic [hibm_pkg::PIX_W-1:0]           blur_b_i,
  input  logic [hibm_pkg::PIX_W-1:0]           centre_b_i,
  output logic [hibm_pkg::FIFO_CNT_W-1:0]      fill_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [hibm_pkg::OUT_W-1:0]    merged_twice_o,
  output logic                                 frame_end_o
);

  hibm_pkg::res_t                     fifo_q [hibm_pkg::FIFO_DEPTH];
  hibm_pkg::res_t                     res;
  logic [hibm_pkg::FIFO_PTR_W-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [hibm_pkg::FIFO_CNT_W-1:0]    count_q, count_d;
  logic                               push, pop;

  always_comb begin
    res.merged    = $signed(hibm_pkg::OUT_W'(blur_a_i)) + $signed(hibm_pkg::OUT_W'(centre_b_i))
                  - $signed(hibm_pkg::OUT_W'(blur_b_i));
    res.frame_end = ctl_i.frame_end;
  end

  assign push = ctl_i.valid;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + hibm_pkg::FIFO_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + hibm_pkg::FIFO_PTR_W'(1) : rd_ptr_q;
    unique case ({push, pop})
      2'b10:   count_d = count_q + hibm_pkg::FIFO_CNT_W'(1);
      2'b01:   count_d = count_q - hibm_pkg::FIFO_CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign out_valid_o    = (count_q != '0);
  assign merged_twice_o = fifo_q[rd_ptr_q].merged;
  assign frame_end_o    = fifo_q[rd_ptr_q].frame_end;
  assign fill_o         = count_q;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the hybrid image blur and merge block.
`timescale 1ns / 100ps

module testbench;
  import hibm_pkg::*;

  // Run shape
  localparam int unsigned RANDOM_ITEMS  = 1200;
  localparam int unsigned SETTLE_CYCLES = 8;     // pipeline depth plus margin before a write
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned LONG_HOLD     = 150;   // receiver hold-off that backs up the input
  localparam int unsigned STALL_LIMIT   = 4000;  // cycles without any transfer

  // Register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_3 = CFG_IDX_W'(3);

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
  } pix_item_t;

  // Clock, reset and block inputs, all known from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  cmd_i       = CMD_PIXEL;
  logic [PIX_W-1:0]      pixel_a_i   = '0;
  logic [PIX_W-1:0]      pixel_b_i   = '0;
  logic                  out_ready_i = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic                    in_ready_o;
  logic                    out_valid_o;
  logic signed [OUT_W-1:0] merged_twice_o;
  logic                    frame_end_o;
  logic                    cfg_ready_o;

  hybrid_image_blur_merge dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .pixel_a_i      (pixel_a_i),
    .pixel_b_i      (pixel_b_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .merged_twice_o (merged_twice_o),
    .frame_end_o    (frame_end_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: geometry registers, three row slots per image and the
  // raster counters of the input and result sides.
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] geo_width;
  logic [CFG_DATA_W-1:0] geo_height;
  logic [PIX_W-1:0]      rows_a [0:NUM_SLOTS*MAX_WIDTH-1];
  logic [PIX_W-1:0]      rows_b [0:NUM_SLOTS*MAX_WIDTH-1];
  int unsigned           in_r, in_c, out_r, out_c;
  bit                    frame_in_done;

  res_t      merged_due [$];     // merged pixels still owed by the block
  pix_item_t pixel_backlog [$];  // items waiting for the input driver

  int error_count   = 0;
  int checked_count = 0;
  int unsigned random_items = 0;

  // Clamp a raw size register to what the block actually uses
  function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] raw, int unsigned top);
    if (raw < MIN_DIM) return MIN_DIM;
    if (raw > top) return top;
    return raw;
  endfunction

  task automatic restart_frame();
    in_r = 0;
    in_c = 0;
    out_r = 0;
    out_c = 0;
    frame_in_done = 1'b0;
  endtask

  // Work out the next merged pixel in raster order and queue it
  task automatic emit_merged_pixel();
    int unsigned w, h, acc_a, acc_b, wt, pos, centre;
    int unsigned rs [3];
    int unsigned cs [3];
    int          val;
    res_t        due;
    bit          last;
    w = clamp_dim(geo_width, MAX_WIDTH);
    h = clamp_dim(geo_height, MAX_HEIGHT);
    // clamp the neighbourhood to the frame edges
    rs[0] = (out_r > 0) ? out_r - 1 : 0;
    rs[1] = out_r;
    rs[2] = (out_r + 1 < h) ? out_r + 1 : h - 1;
    cs[0] = (out_c > 0) ? out_c - 1 : 0;
    cs[1] = out_c;
    cs[2] = (out_c + 1 < w) ? out_c + 1 : w - 1;
    acc_a = 0;
    acc_b = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        wt  = ((i == 1) ? 2 : 1) * ((j == 1) ? 2 : 1);
        pos = (rs[i] % NUM_SLOTS) * MAX_WIDTH + cs[j];
        acc_a += wt * rows_a[pos];
        acc_b += wt * rows_b[pos];
      end
    end
    centre = rows_b[(out_r % NUM_SLOTS) * MAX_WIDTH + out_c];
    val = int'(acc_a >> 4) + int'(centre) - int'(acc_b >> 4);
    last = (out_r == h - 1) && (out_c == w - 1);
    due.merged    = val[OUT_W-1:0];
    due.frame_end = last;
    merged_due.push_back(due);
    if (last) begin
      restart_frame();
    end else begin
      out_c++;
      if (out_c >= w) begin
        out_c = 0;
        out_r++;
      end
    end
  endtask

  // One accepted input transfer: store the pair, then release a result if its
  // whole neighbourhood has arrived, or drain once the frame is complete
  task automatic blur_merge_step(logic cmd, logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    int unsigned w, h, cur, nr, nc;
    w = clamp_dim(geo_width, MAX_WIDTH);
    h = clamp_dim(geo_height, MAX_HEIGHT);
    if (cmd == CMD_FLUSH || frame_in_done) begin
      if (frame_in_done) emit_merged_pixel();
      return;
    end
    if (in_r >= h || in_c >= w) restart_frame();
    rows_a[(in_r % NUM_SLOTS) * MAX_WIDTH + in_c] = a;
    rows_b[(in_r % NUM_SLOTS) * MAX_WIDTH + in_c] = b;
    cur = in_r * w + in_c;
    in_c++;
    if (in_c >= w) begin
      in_c = 0;
      in_r++;
      if (in_r >= h) begin
        in_r = 0;
        frame_in_done = 1'b1;
      end
    end
    if (frame_in_done) begin
      emit_merged_pixel();
      return;
    end
    nr = (out_r + 1 < h) ? out_r + 1 : h - 1;
    nc = (out_c + 1 < w) ? out_c + 1 : w - 1;
    if (nr * w + nc <= cur) emit_merged_pixel();
  endtask

  // A write to a decoded register restarts the frame; line contents stay
  task automatic apply_geometry(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_IMAGE_WIDTH) begin
      geo_width = data;
      restart_frame();
    end else if (idx == CFG_IMAGE_HEIGHT) begin
      geo_height = data;
      restart_frame();
    end
  endtask

  // Mostly back to back, sometimes a short gap, rarely a long one
  function automatic int unsigned pick_gap(bit steady);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Lean on the extremes now and then
  function automatic logic [PIX_W-1:0] rand_pix();
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  task automatic queue_item(logic cmd, logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    pix_item_t it;
    it.cmd = cmd;
    it.a   = a;
    it.b   = b;
    pixel_backlog.push_back(it);
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Input driver: take the next pending item, hold it until the transfer, then
  // leave a random gap before the following one.
  // ---------------------------------------------------------------------------
  int unsigned feed_gap  = 0;
  bit          steady_in = 1'b0;
  pix_item_t   next_item;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cmd_i      <= CMD_PIXEL;
      pixel_a_i  <= '0;
      pixel_b_i  <= '0;
      feed_gap   <= 0;
      steady_in  <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) blur_merge_step(cmd_i, pixel_a_i, pixel_b_i);
      // switch now and then into a stretch without idling
      if ($urandom_range(0, 511) == 0) steady_in <= !steady_in;
      if (!in_valid_i || in_ready_o) begin
        if (feed_gap != 0) begin
          in_valid_i <= 1'b0;
          feed_gap   <= feed_gap - 1;
        end else if (pixel_backlog.size() != 0) begin
          next_item  = pixel_backlog.pop_front();
          in_valid_i <= 1'b1;
          cmd_i      <= next_item.cmd;
          pixel_a_i  <= next_item.a;
          pixel_b_i  <= next_item.b;
          feed_gap   <= pick_gap(steady_in);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and receiver: check each transfer against the oldest owed
  // pixel, and stall at random. Once, hold off long enough to fill the block.
  // ---------------------------------------------------------------------------
  int unsigned stall_left     = 0;
  int unsigned sink_hold      = 0;
  bit          steady_out     = 1'b0;
  bit          long_hold_done = 1'b0;
  res_t        seen_due;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i    <= 1'b0;
      stall_left     <= 0;
      steady_out     <= 1'b0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        checked_count <= checked_count + 1;
        if (merged_due.size() == 0) begin
          $error("merged_twice: unexpected result %0d (frame_end %0b)",
                 merged_twice_o, frame_end_o);
          error_count++;
        end else begin
          seen_due = merged_due.pop_front();
          if (merged_twice_o !== seen_due.merged) begin
            $error("merged_twice: expected %0d, actual %0d", seen_due.merged, merged_twice_o);
            error_count++;
          end
          if (frame_end_o !== seen_due.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", seen_due.frame_end, frame_end_o);
            error_count++;
          end
        end
      end
      if ($urandom_range(0, 255) == 0) steady_out <= !steady_out;
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= stall_left - 1;
      end else if (!long_hold_done && checked_count >= 40) begin
        // long hold-off while the sender keeps offering
        out_ready_i    <= 1'b0;
        stall_left     <= LONG_HOLD;
        long_hold_done <= 1'b1;
      end else begin
        sink_hold = ($urandom_range(0, 3) == 0) ? pick_gap(steady_out) : 0;
        out_ready_i <= (sink_hold == 0);
        if (sink_hold != 0) stall_left <= sink_hold - 1;
      end
    end
  end

  // Follow register writes into the shadow
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) apply_geometry(cfg_index_i, cfg_data_i);
  end

  // Watchdog: end the run if no transfer of any kind happens for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("hybrid_image_blur_merge test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing
  // ---------------------------------------------------------------------------

  // Wait until every queued item has gone in and every owed result has come out
  task automatic wait_drained();
    @(negedge clk_i);
    while (pixel_backlog.size() != 0 || in_valid_i || merged_due.size() != 0)
      @(negedge clk_i);
  endtask

  // Register write with the block idle; let items that owe nothing clear first
  task automatic write_geometry(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // One frame of random pairs, then enough drain steps to empty it. Stray
  // flushes go in mid-frame; some drain steps are pixels, which the block
  // treats as flushes. A frame may be cut short and left for a write to end.
  task automatic feed_frame(int unsigned w, int unsigned h, bit tally, bit may_cut,
                            output bit cut_short);
    int unsigned total, stop;
    total = w * h;
    stop  = total;
    if (may_cut && $urandom_range(0, 7) == 0) stop = $urandom_range(1, total - 1);
    for (int unsigned k = 0; k < stop; k++) begin
      if ($urandom_range(0, 29) == 0) queue_item(CMD_FLUSH, rand_pix(), rand_pix());
      queue_item(CMD_PIXEL, rand_pix(), rand_pix());
      if (tally) random_items++;
    end
    cut_short = (stop < total);
    if (cut_short) return;
    for (int unsigned k = 0; k <= w; k++) begin
      if ($urandom_range(0, 3) == 0) queue_item(CMD_PIXEL, rand_pix(), rand_pix());
      else queue_item(CMD_FLUSH, rand_pix(), rand_pix());
      if (tally) random_items++;
    end
    // a flush with nothing pending
    if ($urandom_range(0, 4) == 0) queue_item(CMD_FLUSH, rand_pix(), rand_pix());
  endtask

  int unsigned           phase_no;
  int unsigned           roll, frames;
  logic [CFG_DATA_W-1:0] w_raw, h_raw;
  bit                    big, cut_short;

  initial begin
    geo_width  = RESET_WIDTH;
    geo_height = RESET_HEIGHT;
    for (int i = 0; i < NUM_SLOTS * MAX_WIDTH; i++) begin
      rows_a[i] = '0;
      rows_b[i] = '0;
    end
    restart_frame();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: smallest frame through out-of-range sizes
    write_geometry(CFG_IMAGE_WIDTH, CFG_DATA_W'(2));
    write_geometry(CFG_IMAGE_HEIGHT, CFG_DATA_W'(0));
    queue_item(CMD_FLUSH, '0, '0);                // flush before anything arrives
    queue_item(CMD_PIXEL, 8'h00, 8'hFF);
    queue_item(CMD_PIXEL, 8'hFF, 8'h00);
    queue_item(CMD_PIXEL, 8'h55, 8'hAA);
    queue_item(CMD_PIXEL, 8'hAA, 8'h55);
    write_geometry(CFG_UNMAPPED_2, CFG_DATA_W'(11'h7FF));  // undecoded: frame goes on
    queue_item(CMD_FLUSH, 8'hFF, 8'hFF);          // flush mid-frame: ignored
    queue_item(CMD_PIXEL, 8'hFF, 8'hFF);
    queue_item(CMD_PIXEL, 8'h00, 8'h00);
    queue_item(CMD_PIXEL, 8'hFF, 8'h00);
    queue_item(CMD_PIXEL, 8'h00, 8'hFF);
    queue_item(CMD_PIXEL, 8'h80, 8'h7F);
    queue_item(CMD_FLUSH, '0, '0);                // drain the lagging pixels
    queue_item(CMD_PIXEL, 8'h12, 8'h34);          // pixel while draining acts as flush
    queue_item(CMD_FLUSH, '0, '0);
    queue_item(CMD_FLUSH, '0, '0);
    queue_item(CMD_FLUSH, '0, '0);                // nothing left to drain
    queue_item(CMD_PIXEL, 8'h01, 8'h02);
    queue_item(CMD_PIXEL, 8'h03, 8'h04);
    queue_item(CMD_PIXEL, 8'h05, 8'h06);
    write_geometry(CFG_IMAGE_HEIGHT, CFG_DATA_W'(5));  // restart mid-frame

    // Random phases: mostly small frames, a handful at the largest sizes
    phase_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      big = 1'b1;
      case (phase_no)
        1:  begin w_raw = CFG_DATA_W'(1024); h_raw = CFG_DATA_W'(3);    end
        3:  begin w_raw = CFG_DATA_W'(3);    h_raw = CFG_DATA_W'(1024); end
        5:  begin w_raw = CFG_DATA_W'(2047); h_raw = CFG_DATA_W'(1);    end
        7:  begin w_raw = CFG_DATA_W'(4);    h_raw = CFG_DATA_W'(2047); end
        9:  begin w_raw = CFG_DATA_W'(1025); h_raw = CFG_DATA_W'(3);    end
        default: begin
          big  = 1'b0;
          roll = $urandom_range(0, 99);
          if (roll < 70) begin
            w_raw = CFG_DATA_W'($urandom_range(3, 12));
            h_raw = CFG_DATA_W'($urandom_range(3, 6));
          end else if (roll < 88) begin
            w_raw = CFG_DATA_W'($urandom_range(3, 48));
            h_raw = CFG_DATA_W'($urandom_range(3, 10));
          end else begin
            // sizes below the minimum get clamped up
            w_raw = CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(0, 2)
                                                     : $urandom_range(3, 8));
            h_raw = CFG_DATA_W'($urandom_range(0, 2));
          end
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_geometry(CFG_IMAGE_WIDTH, w_raw);
        write_geometry(CFG_IMAGE_HEIGHT, h_raw);
      end else begin
        write_geometry(CFG_IMAGE_HEIGHT, h_raw);
        write_geometry(CFG_IMAGE_WIDTH, w_raw);
      end
      if ($urandom_range(0, 7) == 0)
        write_geometry($urandom_range(0, 1) ? CFG_UNMAPPED_2 : CFG_UNMAPPED_3,
                       CFG_DATA_W'($urandom_range(0, 2047)));
      frames = big ? 1 : $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        feed_frame(clamp_dim(w_raw, MAX_WIDTH), clamp_dim(h_raw, MAX_HEIGHT),
                   !big, !big, cut_short);
        if (cut_short) break;
      end
      phase_no++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("hybrid_image_blur_merge test passed");
    end else begin
      $display("hybrid_image_blur_merge test failed");
    end
    $finish;
  end

endmodule
